[rtl/core/rtbt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the running tail bounds tracker.
// No dependencies.
package rtbt_pkg;

  localparam int MAX_TAIL_95  = 32;
  localparam int MAX_TAIL_99  = 8;
  localparam int SAMPLE_WIDTH = 32;

  // fill counts hold 0..depth, cell indexes 0..depth-1
  localparam int CNT95_W = $clog2(MAX_TAIL_95 + 1);
  localparam int CNT99_W = $clog2(MAX_TAIL_99 + 1);
  localparam int IDX95_W = (MAX_TAIL_95 > 1) ? $clog2(MAX_TAIL_95) : 1;
  localparam int IDX99_W = (MAX_TAIL_99 > 1) ? $clog2(MAX_TAIL_99) : 1;

  // configuration register fields
  localparam int KEEP95_W   = 6;
  localparam int KEEP99_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_95 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_99 = 1'd1;

  localparam logic [KEEP95_W-1:0] KEEP95_RST = 6'd25;
  localparam logic [KEEP99_W-1:0] KEEP99_RST = 4'd5;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // per-cell controls from the store front end
  typedef struct packed {
    logic shift_en;  // request accepted: cells update this cycle
    logic desc;      // store ordered largest first
    logic beyond;    // cell index at or past the live count
  } cell_ctl_t;

endpackage

[rtl/core/rtbt_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample input, bounds result, config write.
// Depends on rtbt_pkg.
interface rtbt_in_if;
  logic                 valid;
  logic                 ready;
  rtbt_pkg::sample_t    sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rtbt_out_if;
  logic                 valid;
  logic                 ready;
  rtbt_pkg::sample_t    low_95;
  rtbt_pkg::sample_t    high_95;
  rtbt_pkg::sample_t    low_99;
  rtbt_pkg::sample_t    high_99;
  logic                 full_95;
  logic                 full_99;
  modport source (output valid, output low_95, output high_95, output low_99,
                  output high_99, output full_95, output full_99, input ready);
  modport sink   (input valid, input low_95, input high_95, input low_99,
                  input high_99, input full_95, input full_99, output ready);
endinterface

interface rtbt_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rtbt_pkg::CFG_IDX_W-1:0]      idx;
  logic [rtbt_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

[rtl/core/rtbt_cell.sv]
`timescale 1ns / 1ps
// One entry of a sorted insert chain: holds a sample, compares it with the
// incoming key and takes the key or its left neighbor. Depends on rtbt_pkg.
module rtbt_cell (
  input  logic                clk,
  input  rtbt_pkg::cell_ctl_t ctl,
  input  rtbt_pkg::sample_t   key,
  input  rtbt_pkg::sample_t   left_val,
  input  logic                left_take,
  output rtbt_pkg::sample_t   val,
  output logic                take
);
  import rtbt_pkg::*;

  sample_t val_r;
  sample_t val_nxt;

  // take: key belongs at or before this slot; monotone along the chain
  assign take = ctl.beyond || (ctl.desc ? (val_r < key) : (val_r > key));

  always_comb begin
    if (!take) begin
      val_nxt = val_r;
    end else if (left_take) begin
      val_nxt = left_val;
    end else begin
      val_nxt = key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

[rtl/core/running_tail_bounds_tracker.sv]
`timescale 1ns / 1ps
// Each request is inserted into the cell stores, then read out into registers.
// Throughput: one request per cycle while results are taken; the sorted
// insert chains compare every cell against the key in parallel.
// Reset (synchronous, rst_n low): stores empty, keep_95 = 25, keep_99 = 5.
// Depends on rtbt_pkg, rtbt_if and rtbt_cell.
module running_tail_bounds_tracker (
  input  logic        clk,
  input  logic        rst_n,
  rtbt_in_if.sink     in_ch,
  rtbt_out_if.source  out_ch,
  rtbt_cfg_if.sink    cfg_ch
);
  import rtbt_pkg::*;

  logic [KEEP95_W-1:0] keep95_r;
  logic [KEEP99_W-1:0] keep99_r;
  logic [CNT95_W-1:0]  fill95_r, fill95_nxt, k95, n95;
  logic [CNT99_W-1:0]  fill99_r, fill99_nxt, k99, n99;
  logic                pend_r;
  logic                out_valid_r;
  logic                accept;
  logic                out_load;
  sample_t             key;

  sample_t low95_r, high95_r, low99_r, high99_r;
  logic    full95_r, full99_r;

  sample_t lo95_val [MAX_TAIL_95];
  sample_t hi95_val [MAX_TAIL_95];
  sample_t lo99_val [MAX_TAIL_99];
  sample_t hi99_val [MAX_TAIL_99];
  logic [MAX_TAIL_95-1:0] lo95_take, hi95_take;
  logic [MAX_TAIL_99-1:0] lo99_take, hi99_take;

  logic [IDX95_W-1:0] last95;
  logic [IDX99_W-1:0] last99;

  assign key      = in_ch.sample;
  assign out_load = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pend_r || out_load;
  assign accept   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // effective keep counts: zero acts as one, saturate at store depth
  always_comb begin
    if (keep95_r == '0) begin
      k95 = CNT95_W'(1);
    end else if (32'(keep95_r) > 32'(MAX_TAIL_95)) begin
      k95 = CNT95_W'(MAX_TAIL_95);
    end else begin
      k95 = CNT95_W'(keep95_r);
    end
    if (keep99_r == '0) begin
      k99 = CNT99_W'(1);
    end else if (32'(keep99_r) > 32'(MAX_TAIL_99)) begin
      k99 = CNT99_W'(MAX_TAIL_99);
    end else begin
      k99 = CNT99_W'(keep99_r);
    end
  end

  // live count after trimming to a lowered keep
  assign n95 = (fill95_r > k95) ? k95 : fill95_r;
  assign n99 = (fill99_r > k99) ? k99 : fill99_r;
  assign fill95_nxt = (n95 < k95) ? n95 + CNT95_W'(1) : n95;
  assign fill99_nxt = (n99 < k99) ? n99 + CNT99_W'(1) : n99;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TAIL_95; gi++) begin : g_c95
      cell_ctl_t ctl_lo, ctl_hi;
      assign ctl_lo = '{shift_en: accept, desc: 1'b0,
                        beyond: (32'(gi) >= 32'(n95))};
      assign ctl_hi = '{shift_en: accept, desc: 1'b1,
                        beyond: (32'(gi) >= 32'(n95))};
      if (gi == 0) begin : g_head
        rtbt_cell u_lo (.clk, .ctl(ctl_lo), .key, .left_val(key), .left_take(1'b0),
                        .val(lo95_val[gi]), .take(lo95_take[gi]));
        rtbt_cell u_hi (.clk, .ctl(ctl_hi), .key, .left_val(key), .left_take(1'b0),
                        .val(hi95_val[gi]), .take(hi95_take[gi]));
      end else begin : g_body
        rtbt_cell u_lo (.clk, .ctl(ctl_lo), .key, .left_val(lo95_val[gi-1]),
                        .left_take(lo95_take[gi-1]),
                        .val(lo95_val[gi]), .take(lo95_take[gi]));
        rtbt_cell u_hi (.clk, .ctl(ctl_hi), .key, .left_val(hi95_val[gi-1]),
                        .left_take(hi95_take[gi-1]),
                        .val(hi95_val[gi]), .take(hi95_take[gi]));
      end
    end
    for (gi = 0; gi < MAX_TAIL_99; gi++) begin : g_c99
      cell_ctl_t ctl_lo, ctl_hi;
      assign ctl_lo = '{shift_en: accept, desc: 1'b0,
                        beyond: (32'(gi) >= 32'(n99))};
      assign ctl_hi = '{shift_en: accept, desc: 1'b1,
                        beyond: (32'(gi) >= 32'(n99))};
      if (gi == 0) begin : g_head
        rtbt_cell u_lo (.clk, .ctl(ctl_lo), .key, .left_val(key), .left_take(1'b0),
                        .val(lo99_val[gi]), .take(lo99_take[gi]));
        rtbt_cell u_hi (.clk, .ctl(ctl_hi), .key, .left_val(key), .left_take(1'b0),
                        .val(hi99_val[gi]), .take(hi99_take[gi]));
      end else begin : g_body
        rtbt_cell u_lo (.clk, .ctl(ctl_lo), .key, .left_val(lo99_val[gi-1]),
                        .left_take(lo99_take[gi-1]),
                        .val(lo99_val[gi]), .take(lo99_take[gi]));
        rtbt_cell u_hi (.clk, .ctl(ctl_hi), .key, .left_val(hi99_val[gi-1]),
                        .left_take(hi99_take[gi-1]),
                        .val(hi99_val[gi]), .take(hi99_take[gi]));
      end
    end
  endgenerate

  // bound sits in the last live cell; fill is at least one once pending
  assign last95 = IDX95_W'(fill95_r - CNT95_W'(1));
  assign last99 = IDX99_W'(fill99_r - CNT99_W'(1));

  always_ff @(posedge clk) begin
    if (out_load) begin
      low95_r  <= lo95_val[last95];
      high95_r <= hi95_val[last95];
      low99_r  <= lo99_val[last99];
      high99_r <= hi99_val[last99];
      full95_r <= (fill95_r == k95);
      full99_r <= (fill99_r == k99);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep95_r    <= KEEP95_RST;
      keep99_r    <= KEEP99_RST;
      fill95_r    <= '0;
      fill99_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.idx)
          REG_KEEP_95: keep95_r <= cfg_ch.data[KEEP95_W-1:0];
          REG_KEEP_99: keep99_r <= cfg_ch.data[KEEP99_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        fill95_r <= fill95_nxt;
        fill99_r <= fill99_nxt;
      end
      if (accept) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.low_95  = low95_r;
  assign out_ch.high_95 = high95_r;
  assign out_ch.low_99  = low99_r;
  assign out_ch.high_99 = high99_r;
  assign out_ch.full_95 = full95_r;
  assign out_ch.full_99 = full99_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(fill95_r) <= 32'(MAX_TAIL_95)) && (32'(fill99_r) <= 32'(MAX_TAIL_99)))
    else $error("fill count past store depth");

  a_accept_pend: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pend_r && (fill95_r != '0) && (fill99_r != '0))
    else $error("accepted request left no pending result");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load did not raise valid");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !out_load |-> !in_ch.ready)
    else $error("request taken while previous result still pending");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for running_tail_bounds_tracker: directed rows, then random
// phases with keep-count changes; results compared against a sorted-store predictor.
// Depends on rtbt_pkg, rtbt_if and the tracker RTL.
module tb;
  import rtbt_pkg::*;

  localparam sample_t S_MIN = 32'sh80000000;
  localparam sample_t S_MAX = 32'sh7FFFFFFF;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CALM_TAIL = 200;  // phases starting in the last requests run without idling
  localparam int N_ROWS = 32;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct packed {
    sample_t low_95;
    sample_t high_95;
    sample_t low_99;
    sample_t high_99;
    logic    full_95;
    logic    full_99;
  } bounds_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    sample_t               sample;
    logic                  typed;
    bounds_t               bounds;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rtbt_in_if  in_ch ();
  rtbt_out_if out_ch ();
  rtbt_cfg_if cfg_ch ();

  running_tail_bounds_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state: ascending smallest-k, descending largest-k
  sample_t low95_store[$];
  sample_t high95_store[$];
  sample_t low99_store[$];
  sample_t high99_store[$];
  logic [KEEP95_W-1:0] keep95_reg = KEEP95_RST;
  logic [KEEP99_W-1:0] keep99_reg = KEEP99_RST;

  bounds_t pending_bounds[$];
  int      errors = 0;
  bit      idle_on = 1'b0;
  int      hold_left = 0;
  sample_t ramp_val = '0;
  int      ramp_step = 0;

  stim_row_t dir_rows[N_ROWS];
  logic [CFG_DATA_W-1:0] keep95_plan[8] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd25, 6'd2, 6'd31, 6'd33};
  logic [CFG_DATA_W-1:0] keep99_plan[8] = '{6'd1, 6'd8, 6'd0, 6'd63, 6'd5, 6'd8, 6'd3, 6'd9};

  function automatic int clamp_keep(int reg_val, int depth);
    if (reg_val == 0) return 1;
    if (reg_val > depth) return depth;
    return reg_val;
  endfunction

  // cut to k first (keeps the extremes), then sorted insert after equal entries
  function automatic void tail_insert(ref sample_t store[$], input int k, input sample_t s,
                                      input bit desc);
    int pos = 0;
    while (store.size() > k) void'(store.pop_back());
    while (pos < store.size() && (desc ? !(store[pos] < s) : !(store[pos] > s))) pos++;
    if (pos < k) begin
      store.insert(pos, s);
      if (store.size() > k) void'(store.pop_back());
    end
  endfunction

  function automatic bounds_t predict_bounds(sample_t s);
    bounds_t b;
    int k95;
    int k99;
    k95 = clamp_keep(int'(keep95_reg), MAX_TAIL_95);
    k99 = clamp_keep(int'(keep99_reg), MAX_TAIL_99);
    tail_insert(low95_store, k95, s, 1'b0);
    tail_insert(high95_store, k95, s, 1'b1);
    tail_insert(low99_store, k99, s, 1'b0);
    tail_insert(high99_store, k99, s, 1'b1);
    b.low_95  = low95_store[low95_store.size() - 1];
    b.high_95 = high95_store[high95_store.size() - 1];
    b.low_99  = low99_store[low99_store.size() - 1];
    b.high_99 = high99_store[high99_store.size() - 1];
    b.full_95 = (low95_store.size() == k95);
    b.full_99 = (low99_store.size() == k99);
    return b;
  endfunction

  function automatic stim_row_t sample_row(sample_t s);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.sample = s;
    return r;
  endfunction

  function automatic stim_row_t typed_row(sample_t s, sample_t lo95, sample_t hi95,
                                          sample_t lo99, sample_t hi99, logic f95, logic f99);
    stim_row_t r;
    r = sample_row(s);
    r.typed = 1'b1;
    r.bounds = '{lo95, hi95, lo99, hi99, f95, f99};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_data = d;
    return r;
  endfunction

  function automatic sample_t rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return sample_t'($urandom);
    if (pick < 7) return sample_t'((int'($urandom_range(0, 7)) - 4) <<< 16);
    if (pick < 9) begin
      ramp_val = ramp_val + ramp_step;
      return ramp_val;
    end
    case ($urandom_range(0, 5))
      0: return S_MIN;
      1: return S_MAX;
      2: return S_MIN + 1;
      3: return S_MAX - 1;
      4: return '0;
      default: return -1;
    endcase
  endfunction

  // starts and ends on a falling edge; valid stays high unless a gap is inserted
  task automatic send_sample(sample_t s, logic typed, bounds_t typed_b);
    int gap;
    bounds_t b;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    b = predict_bounds(s);
    pending_bounds.insert(pending_bounds.size(), typed ? typed_b : b);
    @(negedge clk);
  endtask

  // keep counts change only with the block drained
  task automatic write_keep(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    in_ch.valid <= 1'b0;
    while (pending_bounds.size() != 0) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_KEEP_95) keep95_reg = d[KEEP95_W-1:0];
    else keep99_reg = d[KEEP99_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result receiver: random stall bursts while idling is enabled
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    bounds_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bounds.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h %h %h %h %b %b", $time,
                 out_ch.low_95, out_ch.high_95, out_ch.low_99, out_ch.high_99,
                 out_ch.full_95, out_ch.full_99);
        errors++;
      end else begin
        want = pending_bounds.pop_front();
        check_field("low_95", want.low_95, out_ch.low_95);
        check_field("high_95", want.high_95, out_ch.high_95);
        check_field("low_99", want.low_99, out_ch.low_99);
        check_field("high_99", want.high_99, out_ch.high_99);
        check_field("full_95", {31'b0, want.full_95}, {31'b0, out_ch.full_95});
        check_field("full_99", {31'b0, want.full_99}, {31'b0, out_ch.full_99});
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int n_items;
    bounds_t no_b;
    no_b = '0;
    sent = 0;
    phase = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = '0;
    cfg_ch.data = '0;

    dir_rows = '{
      typed_row(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 1'b0, 1'b0),
      typed_row(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, 1'b0, 1'b0),
      sample_row(32'sh00000000),
      sample_row(32'sh55555555),
      sample_row(32'shAAAAAAAA),
      sample_row(32'shFFFFFFFF),
      // zero keep acts as one; the stores get cut on the next request
      cfg_row(REG_KEEP_95, 6'd0),
      cfg_row(REG_KEEP_99, 6'd0),
      typed_row(32'sh00000000, S_MIN, S_MAX, S_MIN, S_MAX, 1'b1, 1'b1),
      typed_row(S_MIN, S_MIN, S_MAX, S_MIN, S_MAX, 1'b1, 1'b1),
      typed_row(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 1'b1, 1'b1),
      // above depth saturates; keep_99 sees only the low nibble
      cfg_row(REG_KEEP_95, 6'd63),
      cfg_row(REG_KEEP_99, 6'd63),
      sample_row(32'sh00010000),
      sample_row(32'sh00010000),
      sample_row(32'sh00010000),
      sample_row(32'sh00000001),
      sample_row(32'shFFFF0000),
      sample_row(32'sh00018000),
      cfg_row(REG_KEEP_95, 6'd32),
      cfg_row(REG_KEEP_99, 6'd9),
      sample_row(32'sh7FFF0000),
      sample_row(32'sh80010000),
      cfg_row(REG_KEEP_95, 6'd1),
      cfg_row(REG_KEEP_99, 6'd1),
      sample_row(32'sh12345678),
      cfg_row(REG_KEEP_95, 6'd2),
      cfg_row(REG_KEEP_99, 6'd7),
      sample_row(32'sh00000001),
      sample_row(32'shFFFFFFFE),
      sample_row(32'sh40000000),
      sample_row(32'shC0000000)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_on = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_keep(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      else send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].bounds);
    end

    while (sent < RANDOM_ITEMS) begin
      if (phase < 8) begin
        write_keep(REG_KEEP_95, keep95_plan[phase]);
        write_keep(REG_KEEP_99, keep99_plan[phase]);
      end else begin
        write_keep(REG_KEEP_95, CFG_DATA_W'($urandom));
        write_keep(REG_KEEP_99, CFG_DATA_W'($urandom));
      end
      ramp_val = sample_t'($urandom);
      ramp_step = (int'($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 16);
      n_items = $urandom_range(60, 180);
      if (n_items > RANDOM_ITEMS - sent) n_items = RANDOM_ITEMS - sent;
      idle_on = ($urandom_range(0, 3) != 0) && (sent < RANDOM_ITEMS - CALM_TAIL);
      repeat (n_items) begin
        send_sample(rand_sample(), 1'b0, no_b);
        sent++;
      end
      phase++;
    end

    idle_on = 1'b0;
    in_ch.valid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("running_tail_bounds_tracker verification clean");
    end else begin
      $display("running_tail_bounds_tracker verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("running_tail_bounds_tracker verification failed");
    $finish;
  end

endmodule
